### design/ptpt_pkg.sv
// Shared constants and types for the prime table primality test block.
`timescale 1ns / 1ps
package ptpt_pkg;

  // Width of a stored prime and the largest candidate that fits it
  localparam int unsigned PrimeBits = 17;
  localparam logic [PrimeBits-1:0] PrimeMax = 17'h1FFFF;

  // Seed primes held in the first four table slots after reset
  localparam int unsigned SeedCount = 4;

  typedef logic [PrimeBits-1:0] prime_t;

  // Request from the sequencer to the shared remainder unit
  typedef struct packed {
    logic   start;
    prime_t dividend;
    prime_t divisor;
  } div_req_t;

  // Answer from the remainder unit
  typedef struct packed {
    logic done;
    logic zero_rem;
  } div_rsp_t;

endpackage

### design/prime_table_primality_test.sv
// Top level: prime table, sequencer and result register of the primality test.
`timescale 1ns / 1ps
// Answers one signed query at a time: is_prime and table_full appear as one
// result word. A query below two skips the table search and goes straight to
// the result. A query within the stored table costs a search of the table,
// entry by entry through a read, a wait and a compare state. A query beyond
// the largest stored prime first extends the table: each 6k-1 / 6k+1
// candidate is trial-divided by the stored primes up to its square root
// through one shared remainder unit. Each divisor costs a table read, a
// square, the hand-off and 17 remainder steps. Time is set by that division
// loop and the single table port. The table is a memory whose first four
// slots always read as the seeds 2, 3, 5 and 7 (reset only sets the count
// to four; no clearing pass). stall_i holding the result word keeps the
// block from accepting the next query; stall_o is high while a query is in
// work or a result waits.
module prime_table_primality_test #(
  parameter int unsigned PRIME_SLOTS = 8192,
  parameter int unsigned VALUE_BITS  = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [VALUE_BITS-1:0] query_value_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic                         is_prime_o,
  output logic                         table_full_o
);

  localparam int unsigned PB = ptpt_pkg::PrimeBits;
  localparam int unsigned AW = $clog2(PRIME_SLOTS);
  localparam int unsigned CW = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned SQW = 2 * PB;

  // Sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LAST   = 4'd1;
  localparam logic [3:0] S_LASTW  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_NEXT   = 4'd4;
  localparam logic [3:0] S_DRD    = 4'd5;
  localparam logic [3:0] S_DWAIT  = 4'd6;
  localparam logic [3:0] S_DSQ    = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_STORE  = 4'd9;
  localparam logic [3:0] S_SRD    = 4'd10;
  localparam logic [3:0] S_SWAIT  = 4'd11;
  localparam logic [3:0] S_SCMP   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0]             state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [VALUE_BITS-1:0]  val_q, val_d;
  logic [PB:0]            cand_q, cand_d;
  logic                   upper_q, upper_d;
  logic [PB-1:0]          last_q, last_d;
  logic [PB-1:0]          dvs_q, dvs_d;
  logic [SQW-1:0]         sq_q;
  logic                   prime_q, prime_d;
  logic                   full_q, full_d;
  logic                   ovalid_q, ovalid_d;

  // Table memory with one write and one registered read
  logic [PB-1:0]          mem [PRIME_SLOTS];
  logic                   we;
  logic [AW-1:0]          waddr, raddr;
  logic [PB-1:0]          wdata, rdata_q, rdata;
  logic [AW-1:0]          raddr_q;

  ptpt_pkg::div_req_t     dreq;
  ptpt_pkg::div_rsp_t     drsp;

  logic                   pos_ge2;
  logic [VALUE_BITS:0]    val_ext;
  logic [VALUE_BITS:0]    last_ext;
  logic [VALUE_BITS:0]    cand_ext;
  logic [VALUE_BITS:0]    rd_ext;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
    raddr_q <= raddr;
  end

  // Seeds read from fixed slots; the first four addresses always return them
  always_comb begin
    rdata = rdata_q;
    if (raddr_q < AW'(ptpt_pkg::SeedCount)) begin
      case (raddr_q[1:0])
        2'd0:    rdata = PB'(2);
        2'd1:    rdata = PB'(3);
        2'd2:    rdata = PB'(5);
        default: rdata = PB'(7);
      endcase
    end
  end

  ptpt_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  // Compare values on a common signed width
  always_comb begin
    val_ext  = {val_q[VALUE_BITS-1], val_q};
    if (VALUE_BITS > PB) begin
      last_ext = (VALUE_BITS + 1)'(last_q);
      rd_ext   = (VALUE_BITS + 1)'(rdata);
      cand_ext = (VALUE_BITS + 1)'(cand_q);
    end else begin
      last_ext = (last_q > PB'({1'b0, {(VALUE_BITS - 1){1'b1}}})) ?
                 {1'b0, {VALUE_BITS{1'b1}}} : (VALUE_BITS + 1)'(last_q);
      rd_ext   = (rdata > PB'({1'b0, {(VALUE_BITS - 1){1'b1}}})) ?
                 {1'b0, {VALUE_BITS{1'b1}}} : (VALUE_BITS + 1)'(rdata);
      cand_ext = (cand_q > (PB + 1)'({1'b0, {(VALUE_BITS - 1){1'b1}}})) ?
                 {1'b0, {VALUE_BITS{1'b1}}} : (VALUE_BITS + 1)'(cand_q);
    end
    pos_ge2 = !val_q[VALUE_BITS-1] && (val_q >= VALUE_BITS'(2));
  end

  // Square the divisor in its own registered step
  always_ff @(posedge clk_i) begin
    sq_q <= SQW'(dvs_q) * SQW'(dvs_q);
  end

  // Sequencer: extend, divide, search
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    val_d    = val_q;
    cand_d   = cand_q;
    upper_d  = upper_q;
    last_d   = last_q;
    dvs_d    = dvs_q;
    prime_d  = prime_q;
    full_d   = full_q;
    ovalid_d = ovalid_q;
    we       = 1'b0;
    waddr    = count_q[AW-1:0];
    wdata    = cand_q[PB-1:0];
    raddr    = idx_q[AW-1:0];
    dreq.start    = 1'b0;
    dreq.dividend = cand_q[PB-1:0];
    dreq.divisor  = dvs_q;
    if (ovalid_q && !stall_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (valid_i && !ovalid_q) begin
          val_d   = query_value_i;
          prime_d = 1'b0;
          full_d  = 1'b0;
          idx_d   = count_q - CW'(1);
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_LASTW;
      end
      S_LASTW: begin
        last_d  = rdata;
        cand_d  = {1'b0, rdata};
        upper_d = 1'b1;
        if (!pos_ge2) begin
          state_d = S_OUT;
        end else if (val_ext > (VALUE_BITS + 1)'({1'b0, last_ext[VALUE_BITS-1:0]})
                     && !last_ext[VALUE_BITS]) begin
          state_d = S_NEXT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_NEXT: begin
        // Step to 6k-1 (+4) or 6k+1 (+2)
        if (count_q >= CW'(PRIME_SLOTS)) begin
          state_d = S_CHECK;
        end else begin
          cand_d  = cand_q + (upper_q ? (PB + 1)'(4) : (PB + 1)'(2));
          upper_d = !upper_q;
          if ((cand_q + (upper_q ? (PB + 1)'(4) : (PB + 1)'(2)))
              > (PB + 1)'(ptpt_pkg::PrimeMax)) begin
            state_d = S_CHECK;
          end else begin
            idx_d   = '0;
            state_d = S_DRD;
          end
        end
      end
      S_DRD: begin
        if (idx_q >= count_q) begin
          state_d = S_STORE;
        end else begin
          state_d = S_DWAIT;
        end
      end
      S_DWAIT: begin
        dvs_d   = rdata;
        state_d = S_DSQ;
      end
      S_DSQ: begin
        // Launch the remainder while the square settles
        dreq.start = 1'b1;
        state_d    = S_DIV;
        if (dvs_q == '0) begin
          state_d = S_STORE;
        end
      end
      S_DIV: begin
        if (sq_q > SQW'(cand_q)) begin
          state_d = S_STORE;
        end else if (drsp.done) begin
          if (drsp.zero_rem) begin
            if (upper_q) begin
              state_d = S_NEXT;
            end else begin
              state_d = S_NEXT;
            end
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_DRD;
          end
        end
      end
      S_STORE: begin
        // Candidate passed: append it
        we      = 1'b1;
        count_d = count_q + CW'(1);
        last_d  = cand_q[PB-1:0];
        state_d = S_NEXT;
        if (count_q + CW'(1) >= CW'(PRIME_SLOTS)) begin
          state_d = S_CHECK;
        end else if (upper_q && (cand_ext >= val_ext)) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!last_ext[VALUE_BITS] && val_ext > last_ext) begin
          full_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          idx_d   = '0;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (idx_q >= count_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SWAIT;
        end
      end
      S_SWAIT: begin
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (rd_ext == val_ext) begin
          prime_d = 1'b1;
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = S_SRD;
        end
      end
      S_OUT: begin
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= CW'(ptpt_pkg::SeedCount);
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    val_q   <= val_d;
    cand_q  <= cand_d;
    upper_q <= upper_d;
    last_q  <= last_d;
    dvs_q   <= dvs_d;
    prime_q <= prime_d;
    full_q  <= full_d;
  end

  assign stall_o      = (state_q != S_IDLE) || ovalid_q;
  assign valid_o      = ovalid_q;
  assign is_prime_o   = prime_q;
  assign table_full_o = full_q;

endmodule

### design/ptpt_rem_unit.sv
// Shared restoring remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps
module ptpt_rem_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptpt_pkg::div_req_t req_i,
  output ptpt_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = ptpt_pkg::PrimeBits;
  localparam int unsigned CntBits = $clog2(W + 1);

  logic               busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [W-1:0]       rem_q, rem_d;
  logic [W-1:0]       dvd_q, dvd_d;
  logic [W-1:0]       dvs_q, dvs_d;
  logic               done_q, done_d;
  logic [W:0]         trial;
  logic [W:0]         shifted;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    shifted = {rem_q, dvd_q[W-1]};
    trial   = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(W);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[W-2:0], 1'b0};
      rem_d = trial[W] ? shifted[W-1:0] : trial[W-1:0];
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.zero_rem = (rem_q == '0);

endmodule
